/* design/u8s_pkg.sv */
package u8s_pkg;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] FFFD_B0 = 8'hEF;
    localparam logic [7:0] FFFD_B1 = 8'hBF;
    localparam logic [7:0] FFFD_B2 = 8'hBD;

    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] MIN_LEN_2 = 21'h000080;
    localparam logic [20:0] MIN_LEN_3 = 21'h000800;
    localparam logic [20:0] MIN_LEN_4 = 21'h010000;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

endpackage

/* design/utf8_sanitize_replace.sv */
// UTF-8 sanitizer: takes one raw byte per transaction and returns the cleaned stream,
// substituting U+FFFD (EF BF BD) for bad leads, broken or invalid sequences and
// sequences cut off by stream_end. Each input transaction is decoded into a result
// buffer of up to six bytes, which drains one byte per unstalled cycle on the result
// channel; run_last marks the final byte caused by an input. An input causing zero
// or one result byte is taken every cycle unless result_stall is high; one causing
// more holds the input side until they drain, the next input being taken in the
// cycle its last byte leaves. Results appear the cycle after the input is taken.
module utf8_sanitize_replace
    import u8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] byte_in,
    input  logic       stream_end,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] byte_out,
    output logic       run_last,
    output logic       is_replacement
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OPEN = 2'd1,
        PH_DROP = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  seq_length_reg, seq_length_next;
    logic [1:0]  bytes_seen_reg, bytes_seen_next;
    logic [20:0] code_point_reg, code_point_next;
    logic [7:0]  held_reg [3];

    logic [CNT_W-1:0] buf_cnt_reg;
    logic [7:0]       buf_byte_reg [MAX_RESULTS];
    logic             buf_repl_reg [MAX_RESULTS];

    logic [CNT_W-1:0] lst_cnt;
    logic [7:0]       lst_byte [MAX_RESULTS];
    logic             lst_repl [MAX_RESULTS];

    logic        held_we;
    logic [1:0]  held_idx;
    logic        accept, take;
    logic        cont, is_ascii, lead2, lead3, lead4;
    logic [2:0]  seen_sum;
    logic [20:0] cp_ext;
    logic        cp_bad;
    logic        fffd_first, run_start, good;
    logic        st_ascii, st_fffd;

    assign accept = item_valid && !item_stall;
    assign take   = result_valid && !result_stall;

    assign item_stall = (buf_cnt_reg > CNT_W'(1))
                     || (buf_cnt_reg == CNT_W'(1) && result_stall);

    assign result_valid   = (buf_cnt_reg != '0);
    assign byte_out       = buf_byte_reg[0];
    assign is_replacement = buf_repl_reg[0];
    assign run_last       = (buf_cnt_reg == CNT_W'(1));

    assign cont     = (byte_in[7:6] == 2'b10);
    assign is_ascii = !byte_in[7];
    assign lead2    = (byte_in[7:5] == 3'b110);
    assign lead3    = (byte_in[7:4] == 4'b1110);
    assign lead4    = (byte_in[7:3] == 5'b11110);
    assign seen_sum = {1'b0, bytes_seen_reg} + 3'd1;
    assign cp_ext   = {code_point_reg[14:0], byte_in[5:0]};

    assign cp_bad = (seq_length_reg == SEQ_LEN_2 && cp_ext < MIN_LEN_2)
                 || (seq_length_reg == SEQ_LEN_3 && cp_ext < MIN_LEN_3)
                 || (seq_length_reg == SEQ_LEN_4 && cp_ext < MIN_LEN_4)
                 || (cp_ext >= SURR_LO && cp_ext <= SURR_HI)
                 || (cp_ext > CP_MAX);

    always_comb
    begin
        phase_next      = phase_reg;
        seq_length_next = seq_length_reg;
        bytes_seen_next = bytes_seen_reg;
        code_point_next = code_point_reg;
        held_we         = 1'b0;
        held_idx        = bytes_seen_reg;
        fffd_first      = 1'b0;
        run_start       = 1'b0;
        good            = 1'b0;
        st_ascii        = 1'b0;
        st_fffd         = 1'b0;

        unique case (phase_reg)
            PH_OPEN:
            begin
                if (!cont)
                begin
                    fffd_first = 1'b1;
                    run_start  = 1'b1;
                end
                else if (seen_sum >= seq_length_reg)
                begin
                    phase_next      = PH_IDLE;
                    seq_length_next = '0;
                    bytes_seen_next = '0;
                    code_point_next = '0;
                    if (cp_bad)
                    begin
                        fffd_first = 1'b1;
                        if (!stream_end)
                            phase_next = PH_DROP;
                    end
                    else
                    begin
                        good = 1'b1;
                    end
                end
                else
                begin
                    held_we         = (bytes_seen_reg != 2'd3);
                    bytes_seen_next = seen_sum[1:0];
                    code_point_next = cp_ext;
                    if (stream_end)
                    begin
                        fffd_first      = 1'b1;
                        phase_next      = PH_IDLE;
                        seq_length_next = '0;
                        bytes_seen_next = '0;
                        code_point_next = '0;
                    end
                end
            end
            PH_DROP:
            begin
                if (cont)
                begin
                    if (stream_end)
                        phase_next = PH_IDLE;
                end
                else
                begin
                    run_start = 1'b1;
                end
            end
            default:
            begin
                run_start = 1'b1;
            end
        endcase

        if (run_start)
        begin
            phase_next      = PH_IDLE;
            seq_length_next = '0;
            bytes_seen_next = '0;
            code_point_next = '0;
            if (is_ascii)
            begin
                st_ascii = 1'b1;
            end
            else if ((lead2 || lead3 || lead4) && !stream_end)
            begin
                phase_next      = PH_OPEN;
                bytes_seen_next = 2'd1;
                held_we         = 1'b1;
                held_idx        = 2'd0;
                if (lead2)
                begin
                    seq_length_next = SEQ_LEN_2;
                    code_point_next = {16'd0, byte_in[4:0]};
                end
                else if (lead3)
                begin
                    seq_length_next = SEQ_LEN_3;
                    code_point_next = {17'd0, byte_in[3:0]};
                end
                else
                begin
                    seq_length_next = SEQ_LEN_4;
                    code_point_next = {18'd0, byte_in[2:0]};
                end
            end
            else
            begin
                st_fffd = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            lst_byte[i] = 8'h00;
            lst_repl[i] = 1'b0;
        end
        lst_cnt = '0;

        if (good)
        begin
            lst_byte[0] = held_reg[0];
            unique case (seq_length_reg)
                SEQ_LEN_3:
                begin
                    lst_byte[1] = held_reg[1];
                    lst_byte[2] = byte_in;
                    lst_cnt     = CNT_W'(3);
                end
                SEQ_LEN_4:
                begin
                    lst_byte[1] = held_reg[1];
                    lst_byte[2] = held_reg[2];
                    lst_byte[3] = byte_in;
                    lst_cnt     = CNT_W'(4);
                end
                default:
                begin
                    lst_byte[1] = byte_in;
                    lst_cnt     = CNT_W'(2);
                end
            endcase
        end
        else
        begin
            if (fffd_first)
            begin
                lst_byte[0] = FFFD_B0;
                lst_byte[1] = FFFD_B1;
                lst_byte[2] = FFFD_B2;
                lst_repl[0] = 1'b1;
                lst_repl[1] = 1'b1;
                lst_repl[2] = 1'b1;
                lst_cnt     = CNT_W'(3);
                if (st_ascii)
                begin
                    lst_byte[3] = byte_in;
                    lst_cnt     = CNT_W'(4);
                end
                else if (st_fffd)
                begin
                    lst_byte[3] = FFFD_B0;
                    lst_byte[4] = FFFD_B1;
                    lst_byte[5] = FFFD_B2;
                    lst_repl[3] = 1'b1;
                    lst_repl[4] = 1'b1;
                    lst_repl[5] = 1'b1;
                    lst_cnt     = CNT_W'(6);
                end
            end
            else if (st_ascii)
            begin
                lst_byte[0] = byte_in;
                lst_cnt     = CNT_W'(1);
            end
            else if (st_fffd)
            begin
                lst_byte[0] = FFFD_B0;
                lst_byte[1] = FFFD_B1;
                lst_byte[2] = FFFD_B2;
                lst_repl[0] = 1'b1;
                lst_repl[1] = 1'b1;
                lst_repl[2] = 1'b1;
                lst_cnt     = CNT_W'(3);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            seq_length_reg <= '0;
            bytes_seen_reg <= '0;
            code_point_reg <= '0;
            buf_cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                seq_length_reg <= seq_length_next;
                bytes_seen_reg <= bytes_seen_next;
                code_point_reg <= code_point_next;
                buf_cnt_reg    <= lst_cnt;
            end
            else if (take)
            begin
                buf_cnt_reg <= buf_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_we)
            held_reg[held_idx] <= byte_in;

        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_byte_reg[i] <= lst_byte[i];
                buf_repl_reg[i] <= lst_repl[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_byte_reg[i] <= buf_byte_reg[i+1];
                buf_repl_reg[i] <= buf_repl_reg[i+1];
            end
        end
    end

endmodule

/* design/u8s_checker.sv */
module u8s_checker
    import u8s_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] byte_out,
    input logic       run_last,
    input logic       is_replacement
);

    // stalled result transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(byte_out)
            && $stable(run_last) && $stable(is_replacement))
        else $error("result payload changed under stall");

    // with nothing pending the input side is always open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty result buffer");

    // replacement sequence is never split across inputs
    a_fffd_lead: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_replacement && byte_out == FFFD_B0 |-> !run_last)
        else $error("run ends inside replacement character");

    a_fffd_next: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && is_replacement && byte_out == FFFD_B0
            |=> result_valid && is_replacement && byte_out == FFFD_B1)
        else $error("replacement character not contiguous");

    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_out[7] |-> !is_replacement)
        else $error("ASCII byte flagged as replacement");

endmodule

bind utf8_sanitize_replace u8s_checker u_u8s_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_stall     (item_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .byte_out       (byte_out),
    .run_last       (run_last),
    .is_replacement (is_replacement)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import u8s_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_OPEN = 2'd1,
        SCAN_DROP = 2'd2
    } scan_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       repl;
    } out_byte_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    logic [7:0] byte_in      = 8'h00;
    logic       stream_end   = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] byte_out;
    logic       run_last;
    logic       is_replacement;

    int tx_idle_pct = 11;
    int rx_idle_pct = 11;
    int err_cnt     = 0;

    // sanitizer state mirror
    scan_state_t scan_st  = SCAN_IDLE;
    logic [2:0]  seq_len  = '0;
    logic [2:0]  seen_cnt = '0;
    logic [7:0]  held [3];
    logic [20:0] cp_acc   = '0;
    out_byte_t   run_q[$];
    out_byte_t   sanitized_q[$];

    utf8_sanitize_replace dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .byte_in        (byte_in),
        .stream_end     (stream_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .byte_out       (byte_out),
        .run_last       (run_last),
        .is_replacement (is_replacement)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void emit(input logic [7:0] b, input logic repl);
        run_q.push_back(out_byte_t'{b, 1'b0, repl});
    endfunction

    function automatic void emit_fffd();
        emit(FFFD_B0, 1'b1);
        emit(FFFD_B1, 1'b1);
        emit(FFFD_B2, 1'b1);
    endfunction

    function automatic void clear_scan();
        scan_st  = SCAN_IDLE;
        seq_len  = '0;
        seen_cnt = '0;
        cp_acc   = '0;
    endfunction

    function automatic void take_lead(input logic [7:0] b, input logic fin);
        clear_scan();
        if (!b[7])
            emit(b, 1'b0);
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (fin)
                emit_fffd();
            else
            begin
                scan_st  = SCAN_OPEN;
                seen_cnt = 3'd1;
                held[0]  = b;
                if (b[7:5] == 3'b110)
                begin
                    seq_len = SEQ_LEN_2;
                    cp_acc  = {16'd0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len = SEQ_LEN_3;
                    cp_acc  = {17'd0, b[3:0]};
                end
                else
                begin
                    seq_len = SEQ_LEN_4;
                    cp_acc  = {18'd0, b[2:0]};
                end
            end
        end
        else
            emit_fffd();
    endfunction

    function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
        logic        cont;
        logic [20:0] cp;
        logic [2:0]  seen;
        logic        bad;
        out_byte_t   ob;
        int          j;
        cont = (b[7:6] == 2'b10);
        case (scan_st)
            SCAN_OPEN:
            begin
                if (!cont)
                begin
                    emit_fffd();
                    take_lead(b, fin);
                end
                else
                begin
                    cp   = {cp_acc[14:0], b[5:0]};
                    seen = seen_cnt + 3'd1;
                    if (seen >= seq_len)
                    begin
                        bad = (seq_len == SEQ_LEN_2 && cp < MIN_LEN_2) ||
                              (seq_len == SEQ_LEN_3 && cp < MIN_LEN_3) ||
                              (seq_len == SEQ_LEN_4 && cp < MIN_LEN_4) ||
                              (cp >= SURR_LO && cp <= SURR_HI) || (cp > CP_MAX);
                        if (bad)
                        begin
                            emit_fffd();
                            clear_scan();
                            if (!fin)
                                scan_st = SCAN_DROP;
                        end
                        else
                        begin
                            for (j = 0; j + 1 < seq_len && j < 3; j++)
                                emit(held[j], 1'b0);
                            emit(b, 1'b0);
                            clear_scan();
                        end
                    end
                    else
                    begin
                        if (seen_cnt < 3)
                            held[seen_cnt] = b;
                        seen_cnt = seen;
                        cp_acc   = cp;
                        if (fin)
                        begin
                            emit_fffd();
                            clear_scan();
                        end
                    end
                end
            end
            SCAN_DROP:
            begin
                if (cont)
                begin
                    if (fin)
                        clear_scan();
                end
                else
                    take_lead(b, fin);
            end
            default:
                take_lead(b, fin);
        endcase
        for (j = 0; j < run_q.size(); j++)
        begin
            ob      = run_q[j];
            ob.last = (j == run_q.size() - 1);
            sanitized_q.push_back(ob);
        end
        run_q.delete();
    endfunction

    // prediction on accepted input, then check of accepted output
    always @(posedge clk)
    begin : chk
        out_byte_t exp_b;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sanitize_byte(byte_in, stream_end);
            if (result_valid && !result_stall)
            begin
                if (sanitized_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction: byte_out %h", $time, byte_out);
                    err_cnt++;
                end
                else
                begin
                    exp_b = sanitized_q.pop_front();
                    if (byte_out !== exp_b.data)
                    begin
                        $display("%0t: byte_out expected %h got %h",
                                 $time, exp_b.data, byte_out);
                        err_cnt++;
                    end
                    if (run_last !== exp_b.last)
                    begin
                        $display("%0t: run_last expected %b got %b",
                                 $time, exp_b.last, run_last);
                        err_cnt++;
                    end
                    if (is_replacement !== exp_b.repl)
                    begin
                        $display("%0t: is_replacement expected %b got %b",
                                 $time, exp_b.repl, is_replacement);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        byte_in    <= b;
        stream_end <= fin;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    // encode cp in len bytes (overlong allowed) and send the first nbytes
    task automatic send_utf8(input logic [20:0] cp, input int len, input int nbytes,
                             input int end_pct, input logic fin_last);
        logic [7:0] enc [4];
        int         k;
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (k = 0; k < nbytes; k++)
            send_byte(enc[k], ((k == nbytes - 1) && fin_last) ||
                              ($urandom_range(0, 99) < end_pct));
    endtask

    task automatic test_pass_through();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_bad_leads();
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_rejected_sequences();
        // overlong, drop ended by ASCII
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        // surrogate
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // above max, drop ended by stream end
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_broken_and_truncated();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_random_stream(input int n_items);
        int          sent;
        int          kind;
        int          len;
        int          nb;
        logic [20:0] cp;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: cp = 21'($urandom_range(0, 'h7F));
                    2: cp = 21'($urandom_range('h80, 'h7FF));
                    3: cp = 21'($urandom_range('h800, 'hFFFF));
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                send_utf8(cp, len, len, 2, 1'b0);
                sent += len;
            end
            else if (kind < 70)
            begin
                len = $urandom_range(2, 4);
                case (len)
                    2: cp = 21'($urandom_range(0, 'h7F));
                    3: cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 'h7FF))
                                                 : 21'($urandom_range('hD800, 'hDFFF));
                    default: cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 'hFFFF))
                                                       : 21'($urandom_range('h110000, 'h1FFFFF));
                endcase
                send_utf8(cp, len, len, 2, 1'b0);
                nb = $urandom_range(0, 2);
                repeat (nb)
                    send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 99) < 5);
                sent += len + nb;
            end
            else if (kind < 82)
            begin
                len = $urandom_range(2, 4);
                cp  = 21'($urandom);
                nb  = $urandom_range(1, len - 1);
                send_utf8(cp, len, nb, 0, $urandom_range(0, 2) == 0);
                sent += nb;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 5);
                sent += 1;
            end
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_stream(n_items);
        tx_idle_pct = 11;
        rx_idle_pct = 11;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pass_through();
        test_bad_leads();
        test_rejected_sequences();
        test_broken_and_truncated();
        test_random_stream(230);
        test_back_to_back(60);
        item_valid <= 1'b0;
        while (sanitized_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("[utf8_sanitize_replace] OK");
        else
            $display("[utf8_sanitize_replace] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("%0t: timeout, %0d bytes still expected", $time, sanitized_q.size());
        $display("[utf8_sanitize_replace] ERROR");
        $finish;
    end

endmodule

/* files.f */
design/u8s_pkg.sv
design/utf8_sanitize_replace.sv
design/u8s_checker.sv
sim/tb_top.sv
